@@ rtl/ntc_pkg.sv @@
`default_nettype none

package ntc_pkg;

   // field and register widths
   localparam int SAMPLE_W   = 13;
   localparam int SUPPLY_W   = 13;
   localparam int RES_W      = 20;
   localparam int BETA_W     = 14;
   localparam int TREF_W     = 15;
   localparam int CEL_W      = 17;
   localparam int FAH_W      = 18;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // log2 unit
   localparam int PROD_W   = 33;
   localparam int MANT_W   = 32;
   localparam int K_W      = 6;
   localparam int FRAC_W   = 16;
   localparam int LOG_ITER = 16;
   localparam int LOG_W    = K_W + FRAC_W;
   localparam int LQ_W     = LOG_W + 1;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // temperature arithmetic
   localparam int T0C_W   = 16;
   localparam int B100_W  = 21;
   localparam int NUM1_W  = 37;
   localparam int NUM_W   = NUM1_W + 16;
   localparam int PRODL_W = 40;
   localparam int DEN_W   = PRODL_W + 1;
   localparam int DIV_D_W = 43;
   localparam int DIV_N_W = 57;
   localparam int QUO_W   = 17;
   localparam int REM_W   = 60;
   localparam int TEMP_W  = 19;

   localparam logic [15:0] KELVIN_OFS_CENTI = 16'd27315;
   localparam logic signed [TEMP_W-1:0] CEL_OFS = 19'sd27315;
   localparam logic signed [TEMP_W-1:0] FAH_OFS = 19'sd45967;
   localparam logic signed [TEMP_W-1:0] CEL_MIN = -19'sd10000;
   localparam logic signed [TEMP_W-1:0] CEL_MAX = 19'sd40000;
   localparam logic signed [TEMP_W-1:0] FAH_MIN = -19'sd16000;
   localparam logic signed [TEMP_W-1:0] FAH_MAX = 19'sd76000;

   // register reset values
   localparam logic [SUPPLY_W-1:0] SUPPLY_RST  = 13'd4990;
   localparam logic [RES_W-1:0]    FIXRES_RST  = 20'd10000;
   localparam logic [RES_W-1:0]    REFRES_RST  = 20'd10000;
   localparam logic [BETA_W-1:0]   BETA_RST    = 14'd3950;
   localparam logic [TREF_W-1:0]   REFTEMP_RST = 15'd2500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUPPLY   = 3'd0,
      CSR_FIXRES   = 3'd1,
      CSR_REFRES   = 3'd2,
      CSR_BETA     = 3'd3,
      CSR_REFTEMP  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [MANT_W-1:0] m;
      logic [K_W-1:0]    k;
      logic [FRAC_W-1:0] f;
   } log_lane_type;

   typedef struct packed {
      log_lane_type a;
      log_lane_type b;
      logic         err;
   } log_stage_type;

   typedef struct packed {
      logic [DIV_N_W-1:0] r;
      logic [DIV_D_W-1:0] d;
      logic [QUO_W-1:0]   q;
      logic               ovf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type c;
      div_lane_type fh;
      logic         dpos;
      logic         err;
   } div_stage_type;

   typedef struct packed {
      logic [FAH_W-1:0] fah;
      logic [CEL_W-1:0] cel;
      logic             err;
   } rsp_type;

   // position of the highest set bit
   function automatic logic [K_W-1:0] msb_index(input logic [PROD_W-1:0] x);
      logic [K_W-1:0] k;
      k = '0;
      for (int i = 0; i < PROD_W; i++) begin
         if (x[i]) k = K_W'(i);
      end
      return k;
   endfunction

   // mantissa in [2^31, 2^32)
   function automatic logic [MANT_W-1:0] normalize(input logic [PROD_W-1:0] x,
                                                   input logic [K_W-1:0] k);
      logic [PROD_W-1:0] sh;
      sh = x << (K_W'(MANT_W - 1) - k);
      if (k > K_W'(MANT_W - 1)) return x[PROD_W-1:1];
      return sh[MANT_W-1:0];
   endfunction

   // one squaring step, returns {fraction bit, new mantissa}
   function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     m2;
      sq = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
      m2 = sq[2*MANT_W-1:MANT_W-1];
      if (m2[MANT_W]) return {1'b1, m2[MANT_W:1]};
      return {1'b0, m2[MANT_W-1:0]};
   endfunction

   // one restoring division step at quotient bit bp
   function automatic div_lane_type div_step(input div_lane_type l, input int unsigned bp);
      logic [REM_W-1:0] dsh;
      logic [REM_W-1:0] rem;
      div_lane_type     o;
      o   = l;
      dsh = REM_W'(l.d) << bp;
      rem = REM_W'(l.r);
      if (rem >= dsh) begin
         o.r = DIV_N_W'(rem - dsh);
         o.q = l.q | (QUO_W'(1) << bp);
      end
      return o;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ntc_thermistor_temperature_core.sv @@
`default_nettype none

// NTC thermistor converter: takes one divider sample in millivolts per transaction and returns
// the beta-equation temperature in hundredths of a degree Celsius and Fahrenheit, rounded to
// nearest and saturated, with a range flag on tuser for a zero sample or one not below the
// supply. The datapath is a 44-stage pipeline (range check, log arguments, leading-one search,
// normalize, sixteen squaring stages of the log2 unit, log difference, ln 2 scaling, two product
// stages, rounding, overflow check, seventeen restoring division stages, output register), so a
// sample may enter every cycle while input is not stalled; its result is offered on rsp from the
// output register. A two-entry output buffer keeps input flowing while one result waits; input
// stalls only when both entries are full.
// Registers are written through the csr port at any time, but only while no sample is in
// flight is the result defined.
module ntc_thermistor_temperature_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [ntc_pkg::REQ_DATA_W-1:0]  req_tdata,   // [12:0] sample_mv
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [ntc_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // [16:0] celsius_centi,
                                                             // [34:17] fahrenheit_centi
   output logic                                 rsp_tuser,   // [0] range_error
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ntc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ntc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ntc_pkg::*;

   // configuration registers
   logic [SUPPLY_W-1:0] supply_ff;
   logic [RES_W-1:0]    fixres_ff;
   logic [RES_W-1:0]    refres_ff;
   logic [BETA_W-1:0]   beta_ff;
   logic [TREF_W-1:0]   reftemp_ff;
   logic [B100_W-1:0]   b100_ff, b100_in;
   logic [T0C_W-1:0]    t0c_ff, t0c_in;
   logic signed [TREF_W+1:0] t0c_sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff  <= SUPPLY_RST;
         fixres_ff  <= FIXRES_RST;
         refres_ff  <= REFRES_RST;
         beta_ff    <= BETA_RST;
         reftemp_ff <= REFTEMP_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SUPPLY:  supply_ff  <= csr_data[SUPPLY_W-1:0];
            CSR_FIXRES:  fixres_ff  <= csr_data;
            CSR_REFRES:  refres_ff  <= csr_data;
            CSR_BETA:    beta_ff    <= csr_data[BETA_W-1:0];
            CSR_REFTEMP: reftemp_ff <= csr_data[TREF_W-1:0];
            default: ;
         endcase
      end
   end

   // derived constants: 100*beta and reference temperature in centi-kelvin
   always_comb begin
      b100_in = B100_W'(beta_ff) * B100_W'(100);
      t0c_sum = $signed({{2{reftemp_ff[TREF_W-1]}}, reftemp_ff})
              + $signed({1'b0, KELVIN_OFS_CENTI});
      t0c_in  = t0c_sum[T0C_W-1:0];
   end

   always_ff @(posedge clock) begin
      b100_ff <= b100_in;
      t0c_ff  <= t0c_in;
   end

   // pipeline advance, stalled only while the skid entry is full
   logic    en;
   logic    out_vld_ff, skid_vld_ff;
   rsp_type out_ff, skid_ff;

   assign en         = ~skid_vld_ff;
   assign req_tready = en;

   // stage 1: range check and supply difference
   logic [SAMPLE_W-1:0] v_in, v1_ff;
   logic [SUPPLY_W-1:0] sv1_ff;
   logic                err1_ff, vld1_ff;

   assign v_in = req_tdata[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff   <= v_in;
         sv1_ff  <= supply_ff - v_in;
         err1_ff <= (v_in == '0) || (v_in >= supply_ff);
      end
   end

   // stage 2: log arguments
   logic [PROD_W-1:0] xa_in, xb_in, xa2_ff, xb2_ff;
   logic              err2_ff, vld2_ff;

   always_comb begin
      xa_in = PROD_W'(fixres_ff) * PROD_W'(v1_ff);
      xb_in = PROD_W'(sv1_ff) * PROD_W'(refres_ff);
      if (xa_in == '0) xa_in = PROD_W'(1);
      if (xb_in == '0) xb_in = PROD_W'(1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xa2_ff  <= xa_in;
         xb2_ff  <= xb_in;
         err2_ff <= err1_ff;
      end
   end

   // stage 3: integer part of log2
   logic [PROD_W-1:0] xa3_ff, xb3_ff;
   logic [K_W-1:0]    ka3_ff, kb3_ff;
   logic              err3_ff, vld3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xa3_ff  <= xa2_ff;
         xb3_ff  <= xb2_ff;
         ka3_ff  <= msb_index(xa2_ff);
         kb3_ff  <= msb_index(xb2_ff);
         err3_ff <= err2_ff;
      end
   end

   // stage 4 and squaring stages: lg_ff[0] is the normalized mantissa
   log_stage_type lg_ff [LOG_ITER+1];
   log_stage_type lg_in [LOG_ITER+1];
   logic [LOG_ITER:0] lg_vld_ff;
   logic [MANT_W:0]   sqa, sqb;

   always_comb begin
      lg_in[0].a.m = normalize(xa3_ff, ka3_ff);
      lg_in[0].a.k = ka3_ff;
      lg_in[0].a.f = '0;
      lg_in[0].b.m = normalize(xb3_ff, kb3_ff);
      lg_in[0].b.k = kb3_ff;
      lg_in[0].b.f = '0;
      lg_in[0].err = err3_ff;
      for (int j = 1; j <= LOG_ITER; j++) begin
         sqa = sq_step(lg_ff[j-1].a.m);
         sqb = sq_step(lg_ff[j-1].b.m);
         lg_in[j]     = lg_ff[j-1];
         lg_in[j].a.m = sqa[MANT_W-1:0];
         lg_in[j].a.f = {lg_ff[j-1].a.f[FRAC_W-2:0], sqa[MANT_W]};
         lg_in[j].b.m = sqb[MANT_W-1:0];
         lg_in[j].b.f = {lg_ff[j-1].b.f[FRAC_W-2:0], sqb[MANT_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= LOG_ITER; j++) lg_ff[j] <= lg_in[j];
      end
   end

   // stage 5: log2 difference, sign and magnitude
   logic signed [LQ_W-1:0] d_in;
   logic [LOG_W-1:0]       mag5_ff;
   logic                   neg5_ff, err5_ff, vld5_ff;

   assign d_in = $signed({1'b0, lg_ff[LOG_ITER].a.k, lg_ff[LOG_ITER].a.f})
               - $signed({1'b0, lg_ff[LOG_ITER].b.k, lg_ff[LOG_ITER].b.f});

   always_ff @(posedge clock) begin
      if (en) begin
         neg5_ff <= d_in[LQ_W-1];
         mag5_ff <= d_in[LQ_W-1] ? LOG_W'(-d_in) : d_in[LOG_W-1:0];
         err5_ff <= lg_ff[LOG_ITER].err;
      end
   end

   // stage 6: scale by ln 2, round half away from zero
   logic [LOG_W+31:0]      ln_prod;
   logic [LQ_W-1:0]        lq_in, lq6_ff;
   logic                   err6_ff, vld6_ff;

   always_comb begin
      ln_prod = (LOG_W+32)'(mag5_ff) * (LOG_W+32)'(LN2_Q32)
              + ((LOG_W+32)'(1) << 31);
      lq_in   = {1'b0, ln_prod[LOG_W+31:32]};
      if (neg5_ff) lq_in = -lq_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lq6_ff  <= lq_in;
         err6_ff <= err5_ff;
      end
   end

   // stage 7: L*T0 and 100*B*T0
   logic [PRODL_W-1:0] prodl7_ff;
   logic [NUM1_W-1:0]  num17_ff;
   logic               err7_ff, vld7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prodl7_ff <= $signed({{(PRODL_W-LQ_W){lq6_ff[LQ_W-1]}}, lq6_ff})
                    * $signed({{(PRODL_W-T0C_W){1'b0}}, t0c_ff});
         num17_ff  <= NUM1_W'(b100_ff) * NUM1_W'(t0c_ff);
         err7_ff   <= err6_ff;
      end
   end

   // stage 8: numerator and denominator
   logic [DEN_W-1:0] den8_ff;
   logic [NUM_W-1:0] num8_ff;
   logic             err8_ff, vld8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         den8_ff <= {prodl7_ff[PRODL_W-1], prodl7_ff}
                  + {{(DEN_W-B100_W-16){1'b0}}, b100_ff, 16'b0};
         num8_ff <= {num17_ff, 16'b0};
         err8_ff <= err7_ff;
      end
   end

   // stage 9: rounded dividends and divisors for both scales
   logic [DIV_D_W-1:0] cd_in, fd_in, cd9_ff, fd9_ff;
   logic [DIV_N_W-1:0] cn9_ff, fn9_ff;
   logic               dpos9_ff, err9_ff, vld9_ff;

   always_comb begin
      cd_in = DIV_D_W'(den8_ff[DEN_W-2:0]);
      fd_in = (cd_in << 2) + cd_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cd9_ff   <= cd_in;
         fd9_ff   <= fd_in;
         cn9_ff   <= DIV_N_W'(num8_ff) + DIV_N_W'(cd_in >> 1);
         fn9_ff   <= (DIV_N_W'(num8_ff) << 3) + DIV_N_W'(num8_ff) + DIV_N_W'(fd_in >> 1);
         dpos9_ff <= ~den8_ff[DEN_W-1] && (den8_ff != '0);
         err9_ff  <= err8_ff;
      end
   end

   // stage 10 and division stages: dv_ff[0] holds the overflow check
   div_stage_type dv_ff [QUO_W+1];
   div_stage_type dv_in [QUO_W+1];
   logic [QUO_W:0] dv_vld_ff;

   always_comb begin
      dv_in[0].c.r   = cn9_ff;
      dv_in[0].c.d   = cd9_ff;
      dv_in[0].c.q   = '0;
      dv_in[0].c.ovf = REM_W'(cn9_ff) >= (REM_W'(cd9_ff) << QUO_W);
      dv_in[0].fh.r   = fn9_ff;
      dv_in[0].fh.d   = fd9_ff;
      dv_in[0].fh.q   = '0;
      dv_in[0].fh.ovf = REM_W'(fn9_ff) >= (REM_W'(fd9_ff) << QUO_W);
      dv_in[0].dpos  = dpos9_ff;
      dv_in[0].err   = err9_ff;
      for (int j = 1; j <= QUO_W; j++) begin
         dv_in[j]    = dv_ff[j-1];
         dv_in[j].c  = div_step(dv_ff[j-1].c, QUO_W - j);
         dv_in[j].fh = div_step(dv_ff[j-1].fh, QUO_W - j);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= QUO_W; j++) dv_ff[j] <= dv_in[j];
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff   <= 1'b0;
         vld2_ff   <= 1'b0;
         vld3_ff   <= 1'b0;
         lg_vld_ff <= '0;
         vld5_ff   <= 1'b0;
         vld6_ff   <= 1'b0;
         vld7_ff   <= 1'b0;
         vld8_ff   <= 1'b0;
         vld9_ff   <= 1'b0;
         dv_vld_ff <= '0;
      end else if (en) begin
         vld1_ff   <= req_tvalid;
         vld2_ff   <= vld1_ff;
         vld3_ff   <= vld2_ff;
         lg_vld_ff <= {lg_vld_ff[LOG_ITER-1:0], vld3_ff};
         vld5_ff   <= lg_vld_ff[LOG_ITER];
         vld6_ff   <= vld5_ff;
         vld7_ff   <= vld6_ff;
         vld8_ff   <= vld7_ff;
         vld9_ff   <= vld8_ff;
         dv_vld_ff <= {dv_vld_ff[QUO_W-1:0], vld9_ff};
      end
   end

   // offset, saturate and range error
   logic signed [TEMP_W-1:0] cs, fs;
   rsp_type                  res_in;

   always_comb begin
      cs = $signed({2'b0, dv_ff[QUO_W].c.q}) - CEL_OFS;
      fs = $signed({2'b0, dv_ff[QUO_W].fh.q}) - FAH_OFS;
      if (!dv_ff[QUO_W].dpos || dv_ff[QUO_W].c.ovf || cs > CEL_MAX) cs = CEL_MAX;
      else if (cs < CEL_MIN) cs = CEL_MIN;
      if (!dv_ff[QUO_W].dpos || dv_ff[QUO_W].fh.ovf || fs > FAH_MAX) fs = FAH_MAX;
      else if (fs < FAH_MIN) fs = FAH_MIN;
      res_in.err = dv_ff[QUO_W].err;
      res_in.cel = dv_ff[QUO_W].err ? '0 : cs[CEL_W-1:0];
      res_in.fah = dv_ff[QUO_W].err ? '0 : fs[FAH_W-1:0];
   end

   // output register with skid entry
   logic take, arrive;

   assign take   = out_vld_ff & rsp_tready;
   assign arrive = en & dv_vld_ff[QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) skid_vld_ff <= 1'b0;
      end else if (arrive) begin
         if (!out_vld_ff || take) out_vld_ff <= 1'b1;
         else skid_vld_ff <= 1'b1;
      end else if (take) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) out_ff <= skid_ff;
      end else if (arrive) begin
         if (!out_vld_ff || take) out_ff <= res_in;
         else skid_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-FAH_W-CEL_W){1'b0}}, out_ff.fah, out_ff.cel};
   assign rsp_tuser  = out_ff.err;

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid entry full while output empty");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("range error with nonzero temperature");

   a_cel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[CEL_W-1:0]) >= -17'sd10000
                   && $signed(rsp_tdata[CEL_W-1:0]) <= 17'sd40000))
      else $error("celsius out of range");

   a_fah_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[CEL_W+FAH_W-1:CEL_W]) >= -18'sd16000
                   && $signed(rsp_tdata[CEL_W+FAH_W-1:CEL_W]) <= 18'sd76000))
      else $error("fahrenheit out of range");

endmodule

`default_nettype wire
